// File: rtl/core/hdtm_pkg.sv
package hdtm_pkg;

    localparam int MAX_ENTRIES    = 256;
    localparam int STATIC_ENTRIES = 62;
    localparam int ENTRY_OVERHEAD = 32;

    localparam int SLOT_W  = $clog2(MAX_ENTRIES);
    localparam int COUNT_W = $clog2(MAX_ENTRIES) + 1;
    localparam int LEN_W   = 16;
    localparam int TOTAL_W = 18;
    localparam int SPOS_W  = 6;

    localparam logic [LEN_W-1:0] SIZE_RESET = 16'd4096;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_SET_MAX = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_INDEX  = 2'd1,
        ST_OVER_LIMIT = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic read;
        logic sub;
        logic store;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_check;
        logic evict_needed;
        logic is_add;
    } dp_status_t;

endpackage

// File: rtl/core/hpack_dynamic_table_manager_unit.sv
// channel   direction  handshake                      payload
// item in   input      start & !busy at clock edge    opcode, name_length, value_length,
//                                                     new_max_size, table_index
// item out  output     done high for one cycle        status, entry_kind, static_position,
//                                                     slot_address, evicted_count,
//                                                     table_cleared, entry_count, used_size
// config    input      cfg_write_enable at edge       cfg_write_data (max size limit)
//
// a resolve, opcode 3, a rejected size update or an oversized add goes from execute straight
// to done; a size update also passes check, and an add passes check and store, with a read,
// a subtract and a check again for each evicted entry
// eviction walks the oldest entries one at a time through the size ram read port
// rst_n is asynchronous; reset empties the table and sets size and limit to 4096
// the size ram needs no clearing since only held entries are ever read
// results cannot be stalled: done lasts exactly one cycle; the result ports hold until the next item is taken
module hpack_dynamic_table_manager_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // item in
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [hdtm_pkg::LEN_W-1:0]    name_length,
    input  logic [hdtm_pkg::LEN_W-1:0]    value_length,
    input  logic [hdtm_pkg::LEN_W-1:0]    new_max_size,
    input  logic [hdtm_pkg::LEN_W-1:0]    table_index,
    // item out
    output logic                          done,
    output logic [1:0]                    status,
    output logic                          entry_kind,
    output logic [hdtm_pkg::SPOS_W-1:0]   static_position,
    output logic [hdtm_pkg::SLOT_W-1:0]   slot_address,
    output logic [hdtm_pkg::COUNT_W-1:0]  evicted_count,
    output logic                          table_cleared,
    output logic [hdtm_pkg::COUNT_W-1:0]  entry_count,
    output logic [hdtm_pkg::LEN_W-1:0]    used_size,
    // config
    input  logic                          cfg_write_enable,
    input  logic [hdtm_pkg::LEN_W-1:0]    cfg_write_data
);

    import hdtm_pkg::*;

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // sequencer: idle, execute, check / read / subtract loop, store, done
    hdtm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // bookkeeping registers, size ram and result registers
    hdtm_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .opcode           (opcode),
        .name_length      (name_length),
        .value_length     (value_length),
        .new_max_size     (new_max_size),
        .table_index      (table_index),
        .status           (status),
        .entry_kind       (entry_kind),
        .static_position  (static_position),
        .slot_address     (slot_address),
        .evicted_count    (evicted_count),
        .table_cleared    (table_cleared),
        .entry_count      (entry_count),
        .used_size        (used_size)
    );

endmodule

// File: rtl/core/hdtm_ram.sv
module hdtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/hdtm_ctrl.sv
module hdtm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hdtm_pkg::dp_status_t sts,
    output hdtm_pkg::ctrl_cmd_t cmd,
    output logic                busy,
    output logic                done
);

    import hdtm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_READ  = 7'b0001000,
        S_SUB   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.go_check ? S_CHECK : S_DONE;
            end
            S_CHECK:
            begin
                if (sts.evict_needed)
                begin
                    state_next = S_READ;
                end
                else if (sts.is_add)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_CHECK;
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// File: rtl/core/hdtm_datapath.sv
module hdtm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hdtm_pkg::ctrl_cmd_t            cmd,
    output hdtm_pkg::dp_status_t           sts,
    input  logic                           cfg_write_enable,
    input  logic [hdtm_pkg::LEN_W-1:0]     cfg_write_data,
    input  logic [1:0]                     opcode,
    input  logic [hdtm_pkg::LEN_W-1:0]     name_length,
    input  logic [hdtm_pkg::LEN_W-1:0]     value_length,
    input  logic [hdtm_pkg::LEN_W-1:0]     new_max_size,
    input  logic [hdtm_pkg::LEN_W-1:0]     table_index,
    output logic [1:0]                     status,
    output logic                           entry_kind,
    output logic [hdtm_pkg::SPOS_W-1:0]    static_position,
    output logic [hdtm_pkg::SLOT_W-1:0]    slot_address,
    output logic [hdtm_pkg::COUNT_W-1:0]   evicted_count,
    output logic                           table_cleared,
    output logic [hdtm_pkg::COUNT_W-1:0]   entry_count,
    output logic [hdtm_pkg::LEN_W-1:0]     used_size
);

    import hdtm_pkg::*;

    // latched item
    op_t    op_reg;
    len_t   name_len_reg;
    len_t   value_len_reg;
    len_t   new_max_reg;
    len_t   index_reg;

    // table bookkeeping
    slot_t  newest_reg,  newest_next;
    count_t held_reg,    held_next;
    total_t total_reg,   total_next;
    len_t   ceiling_reg, ceiling_next;
    len_t   limit_reg;

    // result
    status_t             status_reg,  status_next;
    logic                kind_reg,    kind_next;
    logic [SPOS_W-1:0]   spos_reg,    spos_next;
    slot_t               slot_reg,    slot_next;
    count_t              evicted_reg, evicted_next;
    logic                cleared_reg, cleared_next;

    total_t esize;
    logic   oversize;
    logic   over_limit;
    len_t   dyn_index;
    slot_t  oldest_slot;
    slot_t  store_slot;
    len_t   rd_size;

    assign esize       = TOTAL_W'(ENTRY_OVERHEAD) + TOTAL_W'(name_len_reg)
                         + TOTAL_W'(value_len_reg);
    assign oversize    = (esize > TOTAL_W'(ceiling_reg));
    assign over_limit  = (new_max_reg > limit_reg);
    assign dyn_index   = index_reg - LEN_W'(STATIC_ENTRIES);
    assign oldest_slot = newest_reg + held_reg[SLOT_W-1:0] - SLOT_W'(1);
    assign store_slot  = newest_reg - SLOT_W'(1);

    assign sts.is_add       = (op_reg == OP_ADD);
    assign sts.go_check     = ((op_reg == OP_ADD) && !oversize)
                              || ((op_reg == OP_SET_MAX) && !over_limit);
    // fit eviction and full-ring eviction both take the oldest entry
    assign sts.evict_needed = (held_reg != '0)
                              && ((total_reg > TOTAL_W'(ceiling_reg))
                                  || ((op_reg == OP_ADD)
                                      && (held_reg == COUNT_W'(MAX_ENTRIES))));

    hdtm_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_ENTRIES)
    ) u_sizes (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (store_slot),
        .wdata (esize[LEN_W-1:0]),
        .re    (cmd.read),
        .raddr (oldest_slot),
        .rdata (rd_size)
    );

    always_comb
    begin
        newest_next  = newest_reg;
        held_next    = held_reg;
        total_next   = total_reg;
        ceiling_next = ceiling_reg;
        status_next  = status_reg;
        kind_next    = kind_reg;
        spos_next    = spos_reg;
        slot_next    = slot_reg;
        evicted_next = evicted_reg;
        cleared_next = cleared_reg;

        if (cmd.load)
        begin
            status_next  = ST_OK;
            kind_next    = 1'b0;
            spos_next    = '0;
            slot_next    = '0;
            evicted_next = '0;
            cleared_next = 1'b0;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    if (oversize)
                    begin
                        evicted_next = held_reg;
                        held_next    = '0;
                        total_next   = '0;
                        cleared_next = 1'b1;
                    end
                    else
                    begin
                        total_next = total_reg + esize;
                    end
                end
                OP_SET_MAX:
                begin
                    if (over_limit)
                    begin
                        status_next = ST_OVER_LIMIT;
                    end
                    else
                    begin
                        ceiling_next = new_max_reg;
                    end
                end
                OP_RESOLVE:
                begin
                    if (index_reg == '0)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else if (index_reg < LEN_W'(STATIC_ENTRIES))
                    begin
                        spos_next = index_reg[SPOS_W-1:0];
                    end
                    else if (dyn_index < LEN_W'(held_reg))
                    begin
                        kind_next = 1'b1;
                        slot_next = newest_reg + dyn_index[SLOT_W-1:0];
                    end
                    else
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        if (cmd.sub)
        begin
            total_next   = total_reg - TOTAL_W'(rd_size);
            held_next    = held_reg - COUNT_W'(1);
            evicted_next = evicted_reg + COUNT_W'(1);
        end

        if (cmd.store)
        begin
            newest_next = store_slot;
            held_next   = held_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op_t'(opcode);
            name_len_reg  <= name_length;
            value_len_reg <= value_length;
            new_max_reg   <= new_max_size;
            index_reg     <= table_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg  <= '0;
            held_reg    <= '0;
            total_reg   <= '0;
            ceiling_reg <= SIZE_RESET;
            limit_reg   <= SIZE_RESET;
            status_reg  <= ST_OK;
            kind_reg    <= 1'b0;
            spos_reg    <= '0;
            slot_reg    <= '0;
            evicted_reg <= '0;
            cleared_reg <= 1'b0;
        end
        else
        begin
            newest_reg  <= newest_next;
            held_reg    <= held_next;
            total_reg   <= total_next;
            ceiling_reg <= ceiling_next;
            status_reg  <= status_next;
            kind_reg    <= kind_next;
            spos_reg    <= spos_next;
            slot_reg    <= slot_next;
            evicted_reg <= evicted_next;
            cleared_reg <= cleared_next;
            if (cfg_write_enable)
            begin
                limit_reg <= cfg_write_data;
            end
        end
    end

    assign status          = status_reg;
    assign entry_kind      = kind_reg;
    assign static_position = spos_reg;
    assign slot_address    = slot_reg;
    assign evicted_count   = evicted_reg;
    assign table_cleared   = cleared_reg;
    assign entry_count     = held_reg;
    assign used_size       = total_reg[LEN_W-1:0];

endmodule

// File: verif/hdtm_table_checker.sv
`timescale 1ns / 1ps
module hdtm_table_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   opcode,
    input  hdtm_pkg::len_t               name_length,
    input  hdtm_pkg::len_t               value_length,
    input  hdtm_pkg::len_t               new_max_size,
    input  hdtm_pkg::len_t               table_index,
    input  logic                         done,
    input  logic [1:0]                   status,
    input  logic                         entry_kind,
    input  logic [hdtm_pkg::SPOS_W-1:0]  static_position,
    input  hdtm_pkg::slot_t              slot_address,
    input  hdtm_pkg::count_t             evicted_count,
    input  logic                         table_cleared,
    input  hdtm_pkg::count_t             entry_count,
    input  hdtm_pkg::len_t               used_size,
    input  logic                         cfg_write_enable,
    input  hdtm_pkg::len_t               cfg_write_data,
    output int                           fail_count,
    output int                           pending,
    output int                           results_checked,
    output int                           evictions_seen
);

    import hdtm_pkg::*;

    typedef struct {
        status_t             status;
        logic                kind;
        logic [SPOS_W-1:0]   spos;
        slot_t               slot;
        count_t              evicted;
        logic                cleared;
        count_t              entries;
        len_t                used;
    } table_update_t;

    // shadow copy of the table bookkeeping
    len_t   size_ring [MAX_ENTRIES];
    slot_t  newest;
    count_t held;
    total_t octets;
    len_t   ceiling;
    len_t   size_limit;

    table_update_t predicted_updates [$];
    table_update_t oldest_update;

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        evictions_seen  = 0;
    end

    function automatic count_t drop_oldest();
        if (held == '0)
            return '0;
        octets = octets - total_t'(size_ring[newest + held[SLOT_W-1:0] - slot_t'(1)]);
        held   = held - count_t'(1);
        return count_t'(1);
    endfunction

    function automatic count_t evict_until_fit();
        count_t n;
        n = '0;
        while (octets > total_t'(ceiling) && held != '0)
            n = n + drop_oldest();
        return n;
    endfunction

    function automatic table_update_t predict_table_update(op_t op, len_t nl, len_t vl,
                                                           len_t nm, len_t ti);
        table_update_t r;
        total_t        esize;
        len_t          dyn;
        r.status  = ST_OK;
        r.kind    = 1'b0;
        r.spos    = '0;
        r.slot    = '0;
        r.evicted = '0;
        r.cleared = 1'b0;
        dyn       = ti - len_t'(STATIC_ENTRIES);
        case (op)
            OP_ADD:
            begin
                esize = total_t'(ENTRY_OVERHEAD) + total_t'(nl) + total_t'(vl);
                if (esize > total_t'(ceiling))
                begin
                    // oversized entry empties the whole table
                    r.evicted = held;
                    r.cleared = 1'b1;
                    held      = '0;
                    octets    = '0;
                end
                else
                begin
                    octets    = octets + esize;
                    r.evicted = evict_until_fit();
                    if (held >= count_t'(MAX_ENTRIES))
                        r.evicted = r.evicted + drop_oldest();
                    newest            = newest - slot_t'(1);
                    size_ring[newest] = esize[LEN_W-1:0];
                    held              = held + count_t'(1);
                end
            end
            OP_SET_MAX:
            begin
                if (nm > size_limit)
                    r.status = ST_OVER_LIMIT;
                else
                begin
                    ceiling   = nm;
                    r.evicted = evict_until_fit();
                end
            end
            OP_RESOLVE:
            begin
                if (ti == '0)
                    r.status = ST_BAD_INDEX;
                else if (ti < len_t'(STATIC_ENTRIES))
                    r.spos = ti[SPOS_W-1:0];
                else if (dyn < len_t'(held))
                begin
                    r.kind = 1'b1;
                    r.slot = newest + dyn[SLOT_W-1:0];
                end
                else
                    r.status = ST_BAD_INDEX;
            end
            default:
            begin
            end
        endcase
        r.entries = held;
        r.used    = octets[LEN_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest     = '0;
            held       = '0;
            octets     = '0;
            ceiling    = SIZE_RESET;
            size_limit = SIZE_RESET;
            predicted_updates.delete();
            pending <= 0;
        end
        else
        begin
            // results first: they belong to items accepted at earlier edges
            if (done)
            begin
                if (predicted_updates.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest_update = predicted_updates.pop_front();
                    check_field("status", 32'(oldest_update.status), 32'(status));
                    check_field("entry_kind", 32'(oldest_update.kind), 32'(entry_kind));
                    check_field("static_position", 32'(oldest_update.spos),
                                32'(static_position));
                    check_field("slot_address", 32'(oldest_update.slot), 32'(slot_address));
                    check_field("evicted_count", 32'(oldest_update.evicted),
                                32'(evicted_count));
                    check_field("table_cleared", 32'(oldest_update.cleared),
                                32'(table_cleared));
                    check_field("entry_count", 32'(oldest_update.entries), 32'(entry_count));
                    check_field("used_size", 32'(oldest_update.used), 32'(used_size));
                    results_checked++;
                    evictions_seen += 32'(evicted_count);
                end
            end
            if (cfg_write_enable)
                size_limit = cfg_write_data;
            if (start && !busy)
                predicted_updates.push_back(predict_table_update(op_t'(opcode), name_length,
                                                                 value_length, new_max_size,
                                                                 table_index));
            pending <= predicted_updates.size();
        end
    end

endmodule

// File: verif/hpack_dynamic_table_manager_unit_test.sv
`timescale 1ns / 1ps
module hpack_dynamic_table_manager_unit_test;
    import hdtm_pkg::*;

    // the limit is many times the slowest item, one that walks a full ring of evictions
    localparam int CYCLE_LIMIT   = 2_000_000;
    // pause after the last result before touching the limit register or ending
    localparam int SETTLE_CYCLES = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          opcode = '0;
    len_t                name_length = '0;
    len_t                value_length = '0;
    len_t                new_max_size = '0;
    len_t                table_index = '0;
    logic                done;
    logic [1:0]          status;
    logic                entry_kind;
    logic [SPOS_W-1:0]   static_position;
    slot_t               slot_address;
    count_t              evicted_count;
    logic                table_cleared;
    count_t              entry_count;
    len_t                used_size;
    logic                cfg_write_enable = 1'b0;
    len_t                cfg_write_data = '0;

    int                  fail_count;
    int                  pending;
    int                  results_checked;
    int                  evictions_seen;

    int                  cycle_count = 0;
    int                  burst_left = 4;
    int                  op_seen [4] = '{0, 0, 0, 0};
    int                  limit_writes = 0;
    len_t                cur_limit = SIZE_RESET;

    hpack_dynamic_table_manager_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .name_length      (name_length),
        .value_length     (value_length),
        .new_max_size     (new_max_size),
        .table_index      (table_index),
        .done             (done),
        .status           (status),
        .entry_kind       (entry_kind),
        .static_position  (static_position),
        .slot_address     (slot_address),
        .evicted_count    (evicted_count),
        .table_cleared    (table_cleared),
        .entry_count      (entry_count),
        .used_size        (used_size),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data)
    );

    // watches both channels and the limit writes, predicts and compares
    hdtm_table_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .name_length      (name_length),
        .value_length     (value_length),
        .new_max_size     (new_max_size),
        .table_index      (table_index),
        .done             (done),
        .status           (status),
        .entry_kind       (entry_kind),
        .static_position  (static_position),
        .slot_address     (slot_address),
        .evicted_count    (evicted_count),
        .table_cleared    (table_cleared),
        .entry_count      (entry_count),
        .used_size        (used_size),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_checked  (results_checked),
        .evictions_seen   (evictions_seen)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // present one item and hold it until the block takes it; called at a rising edge
    // start stays high between items of a burst, a burst ends in an idle gap
    task automatic send_item(op_t op, len_t nl, len_t vl, len_t nm, len_t ti);
        start        <= 1'b1;
        opcode       <= op;
        name_length  <= nl;
        value_length <= vl;
        new_max_size <= nm;
        table_index  <= ti;
        do
            @(posedge clk);
        while (busy);
        op_seen[op]++;
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // mostly short bursts, now and then a long stretch with no idling
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(1, 8);
        end
    endtask

    // stop sending and wait until every predicted item has come back
    task automatic wait_drained();
        if (start)
            start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle, never twice in a row
    task automatic write_limit(len_t v);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= v;
        cur_limit         = v;
        limit_writes++;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    // one random item; unused fields carry random bits too
    task automatic random_item();
        int   sel;
        int   r;
        len_t nl;
        len_t vl;
        len_t nm;
        len_t ti;
        sel = $urandom_range(0, 99);
        r   = $urandom_range(0, 9);
        nl  = 16'($urandom);
        vl  = 16'($urandom);
        nm  = 16'($urandom);
        ti  = 16'($urandom);
        if (sel < 45)
        begin
            // add: mostly small entries so the table holds many
            if (r < 6)
            begin
                nl = 16'($urandom_range(0, 120));
                vl = 16'($urandom_range(0, 120));
            end
            else if (r == 8)
            begin
                nl = '0;
                vl = '0;
            end
            else if (r == 9)
                nl = '1;
            send_item(OP_ADD, nl, vl, nm, ti);
        end
        else if (sel < 60)
        begin
            // size update: mostly within the limit
            if (r < 6)
                nm = 16'($urandom_range(0, cur_limit));
            send_item(OP_SET_MAX, nl, vl, nm, ti);
        end
        else if (sel < 95)
        begin
            // resolve: mostly around the static and dynamic range
            if (r < 7)
                ti = 16'($urandom_range(0, STATIC_ENTRIES + MAX_ENTRIES + 4));
            send_item(OP_RESOLVE, nl, vl, nm, ti);
        end
        else
            send_item(OP_NOP, nl, vl, nm, ti);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset limit and size
        write_limit(16'd4096);
        @(posedge clk);
        send_item(OP_RESOLVE, '0, '0, '0, 16'd0);          // index zero is invalid
        send_item(OP_RESOLVE, '0, '0, '0, 16'd1);          // first static entry
        send_item(OP_RESOLVE, '0, '0, '0, 16'd61);         // last static entry
        send_item(OP_RESOLVE, '0, '0, '0, 16'd62);         // dynamic, table still empty
        send_item(OP_RESOLVE, '0, '0, '0, 16'hffff);       // far beyond both tables
        send_item(OP_NOP, '0, '0, '0, '0);
        send_item(OP_ADD, '0, '0, '0, '0);                 // smallest entry, 32 octets
        send_item(OP_RESOLVE, '0, '0, '0, 16'd62);         // newest dynamic entry
        send_item(OP_ADD, 16'd10, 16'd20, '0, '0);
        send_item(OP_RESOLVE, '0, '0, '0, 16'd63);         // oldest of two
        send_item(OP_RESOLVE, '0, '0, '0, 16'd64);         // one past the dynamic table
        send_item(OP_ADD, 16'hffff, 16'hffff, '0, '0);     // oversized add clears the table
        send_item(OP_ADD, 16'd4000, 16'd64, '0, '0);       // entry exactly the maximum size
        send_item(OP_ADD, '0, '0, '0, '0);                 // must evict the big one
        send_item(OP_SET_MAX, '0, '0, 16'd4097, '0);       // just above the limit
        send_item(OP_SET_MAX, '0, '0, 16'hffff, '0);       // far above the limit
        send_item(OP_SET_MAX, '0, '0, 16'd0, '0);          // zero size evicts everything
        send_item(OP_ADD, '0, '0, '0, '0);                 // nothing fits a zero table
        send_item(OP_SET_MAX, '0, '0, 16'd4096, '0);
        send_item(OP_ADD, 16'd100, 16'd100, '0, '0);
        send_item(OP_SET_MAX, '0, '0, 16'd100, '0);        // shrink below the entry
        send_item(OP_NOP, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        wait_drained();

        // widest limit: fill the ring past its 256 slots so it wraps and evicts when full
        write_limit(16'hffff);
        @(posedge clk);
        send_item(OP_SET_MAX, '0, '0, 16'hffff, '0);
        repeat (320)
        begin
            if ($urandom_range(0, 9) != 0)
                send_item(OP_ADD, 16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                          16'($urandom), 16'($urandom));
            else
                send_item(OP_RESOLVE, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(STATIC_ENTRIES, STATIC_ENTRIES + MAX_ENTRIES)));
        end
        send_item(OP_RESOLVE, '0, '0, '0, 16'(STATIC_ENTRIES + MAX_ENTRIES - 1));
        send_item(OP_RESOLVE, '0, '0, '0, 16'(STATIC_ENTRIES + MAX_ENTRIES));
        send_item(OP_ADD, 16'hffff, 16'd0, '0, '0);        // clears a full ring
        repeat (40)
            send_item(OP_ADD, 16'($urandom_range(0, 20)), '0, '0, '0);
        send_item(OP_SET_MAX, '0, '0, 16'd200, '0);        // long eviction walk
        wait_drained();

        // zero limit: only a zero size is accepted
        write_limit(16'd0);
        @(posedge clk);
        send_item(OP_SET_MAX, '0, '0, 16'd1, '0);
        send_item(OP_SET_MAX, '0, '0, 16'd0, '0);
        send_item(OP_ADD, '0, '0, '0, '0);
        send_item(OP_RESOLVE, '0, '0, '0, 16'd62);
        repeat (12)
            random_item();
        wait_drained();

        // random limit and a random mix, with one pause until the table is quiet
        write_limit(16'($urandom_range(1, 65535)));
        @(posedge clk);
        send_item(OP_SET_MAX, '0, '0, cur_limit, '0);
        repeat (50)
            random_item();
        wait_drained();
        repeat (50)
            random_item();
        wait_drained();

        $display("sent %0d adds, %0d size updates, %0d resolves, %0d no-ops under %0d limits",
                 op_seen[OP_ADD], op_seen[OP_SET_MAX], op_seen[OP_RESOLVE], op_seen[OP_NOP],
                 limit_writes);
        $display("checked %0d results, %0d entries evicted in total",
                 results_checked, evictions_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/hdtm_pkg.sv
rtl/core/hdtm_ram.sv
rtl/core/hdtm_ctrl.sv
rtl/core/hdtm_datapath.sv
rtl/core/hpack_dynamic_table_manager_unit.sv
verif/hdtm_table_checker.sv
verif/hpack_dynamic_table_manager_unit_test.sv
